// ===== rtl/core/erq_pkg.sv =====
package erq_pkg;

    // Field widths fixed by the request format
    localparam int TAG_BITS      = 8;
    localparam int POS_BITS      = 4;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Address counter update
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_LAST
    } idx_sel_t;

    // Table write source
    typedef enum logic [1:0] {
        WR_NONE,
        WR_UP,
        WR_DOWN,
        WR_NEW
    } wr_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     accept;
        idx_sel_t idx_sel;
        wr_sel_t  wr_sel;
        logic     load_prev;
        logic     pos_clear;
        logic     pos_from_idx;
        logic     pos_from_count;
        logic     take_head;
        logic     count_inc;
        logic     count_dec;
        logic     finish;
        status_t  fin_status;
        logic     pop_ok;
    } erq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic idx_last;
        logic idx_at_pos;
        logic e_eq_prev;
        logic prev_lt_e;
        logic prev_gt_e;
        logic e_le_cyl;
        logic e_ge_cyl;
        logic prev_le_cyl;
        logic prev_ge_cyl;
    } erq_sts_t;

endpackage

// ===== rtl/core/erq_ram.sv =====
module erq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port (read returns old data)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/erq_dpath.sv =====
module erq_dpath #(
    parameter int DEPTH    = 16,
    parameter int CYL_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  erq_pkg::erq_cmd_t   cmd,
    output erq_pkg::erq_sts_t   sts,
    input  logic [15:0]         cylinder,
    input  logic [7:0]          tag,
    output logic [1:0]          status,
    output logic [3:0]          position,
    output logic [15:0]         head_cylinder,
    output logic [7:0]          head_tag
);
    import erq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = CYL_BITS + TAG_BITS;

    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       pos_reg;
    logic [CYL_BITS-1:0] prev_reg;
    logic [CYL_BITS-1:0] cyl_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [1:0]          status_reg;
    logic [POS_BITS-1:0] position_reg;
    logic [15:0]         head_cyl_reg;
    logic [7:0]          head_tag_reg;

    logic [CW-1:0]       count_m1;
    logic [CW-1:0]       waddr_full;
    logic                we;
    logic [EW-1:0]       wdata;
    logic [EW-1:0]       rdata;
    logic [CYL_BITS-1:0] e_cyl;
    logic [31:0]         cyl_wide;
    logic [31:0]         e_wide;
    logic [31:0]         pos_wide;

    assign count_m1 = count_reg - CW'(1);
    assign cyl_wide = 32'(cylinder);
    assign e_cyl    = rdata[EW-1:TAG_BITS];
    assign e_wide   = 32'(e_cyl);
    assign pos_wide = 32'(pos_reg);

    // Address counter; the read port follows its next value so that
    // rdata always holds the entry at idx_reg
    always_comb
    begin
        case (cmd.idx_sel)
            IDX_HOLD: idx_next = idx_reg;
            IDX_ZERO: idx_next = '0;
            IDX_INC:  idx_next = idx_reg + CW'(1);
            IDX_DEC:  idx_next = idx_reg - CW'(1);
            IDX_LAST: idx_next = count_m1;
            default:  idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_m1;
        end
    end

    // Write port: shift up, shift down or place the new request
    always_comb
    begin
        we         = 1'b1;
        waddr_full = pos_reg;
        wdata      = {cyl_reg, tag_reg};
        case (cmd.wr_sel)
            WR_UP:
            begin
                waddr_full = idx_reg + CW'(1);
                wdata      = rdata;
            end
            WR_DOWN:
            begin
                waddr_full = idx_reg - CW'(1);
                wdata      = rdata;
            end
            WR_NEW:
            begin
                waddr_full = pos_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    erq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr_full[AW-1:0]),
        .wdata (wdata),
        .raddr (idx_next[AW-1:0]),
        .rdata (rdata)
    );

    // Control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Request, scan and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cyl_reg <= cyl_wide[CYL_BITS-1:0];
            tag_reg <= tag;
        end
        if (cmd.pos_clear)
        begin
            pos_reg <= '0;
        end
        else if (cmd.pos_from_idx)
        begin
            pos_reg <= idx_reg;
        end
        else if (cmd.pos_from_count)
        begin
            pos_reg <= count_reg;
        end
        if (cmd.load_prev)
        begin
            prev_reg <= e_cyl;
        end
        if (cmd.take_head)
        begin
            head_cyl_reg <= e_wide[15:0];
            head_tag_reg <= rdata[TAG_BITS-1:0];
        end
        if (cmd.finish)
        begin
            status_reg <= cmd.fin_status;
            if (cmd.fin_status == ST_OK && !cmd.pop_ok)
            begin
                position_reg <= pos_wide[POS_BITS-1:0];
            end
            else
            begin
                position_reg <= '0;
            end
            if (!cmd.pop_ok)
            begin
                head_cyl_reg <= '0;
                head_tag_reg <= '0;
            end
        end
    end

    // Status to the controller
    always_comb
    begin
        sts.count_zero  = (count_reg == '0);
        sts.count_full  = (count_reg == CW'(DEPTH));
        sts.idx_last    = (idx_reg == count_m1);
        sts.idx_at_pos  = (idx_reg == pos_reg);
        sts.e_eq_prev   = (e_cyl == prev_reg);
        sts.prev_lt_e   = (prev_reg < e_cyl);
        sts.prev_gt_e   = (prev_reg > e_cyl);
        sts.e_le_cyl    = (e_cyl <= cyl_reg);
        sts.e_ge_cyl    = (e_cyl >= cyl_reg);
        sts.prev_le_cyl = (prev_reg <= cyl_reg);
        sts.prev_ge_cyl = (prev_reg >= cyl_reg);
    end

    assign status        = status_reg;
    assign position      = position_reg;
    assign head_cylinder = head_cyl_reg;
    assign head_tag      = head_tag_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_inc |-> !sts.count_full)
        else $error("insert into a full table");

    a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_dec |-> !sts.count_zero)
        else $error("pop from an empty table");
`endif

endmodule

// ===== rtl/core/erq_ctrl.sv =====
module erq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              op,
    output logic              busy,
    output logic              done,
    output erq_pkg::erq_cmd_t cmd,
    input  erq_pkg::erq_sts_t sts
);
    import erq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_FIRST,
        S_SKIP,
        S_SWEEP,
        S_PASS,
        S_RETURN,
        S_SHIFT,
        S_WRITE,
        S_POP_HEAD,
        S_POP_SHIFT
    } state_t;

    state_t state_reg, state_next;
    state_t phase_next;
    logic   dir_reg, dir_next;      // 1: first sweep ascends
    logic   done_reg, done_next;
    logic   scan_step;
    logic   consume;

    always_comb
    begin
        state_next     = state_reg;
        dir_next       = dir_reg;
        phase_next     = state_reg;
        scan_step      = 1'b0;
        consume        = 1'b0;
        cmd            = '0;
        cmd.idx_sel    = IDX_HOLD;
        cmd.wr_sel     = WR_NONE;
        cmd.fin_status = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept    = 1'b1;
                    cmd.pos_clear = 1'b1;
                    if (op == OP_INSERT)
                    begin
                        if (sts.count_full)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_FULL;
                        end
                        else if (sts.count_zero)
                        begin
                            state_next = S_WRITE;
                        end
                        else
                        begin
                            cmd.idx_sel = IDX_ZERO;
                            state_next  = S_SCAN_FIRST;
                        end
                    end
                    else
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.idx_sel = IDX_ZERO;
                            state_next  = S_POP_HEAD;
                        end
                    end
                end
            end

            // Head entry seeds the previous cylinder
            S_SCAN_FIRST:
            begin
                scan_step  = 1'b1;
                consume    = 1'b1;
                phase_next = S_SKIP;
            end

            // Skip the leading run of equal cylinders, then pick direction
            S_SKIP:
            begin
                scan_step = 1'b1;
                if (sts.e_eq_prev)
                begin
                    consume = 1'b1;
                end
                else
                begin
                    dir_next = sts.prev_lt_e;
                    if (sts.prev_lt_e ? sts.prev_le_cyl : sts.prev_ge_cyl)
                    begin
                        phase_next = S_SWEEP;
                        consume    = sts.prev_lt_e ? sts.e_le_cyl : sts.e_ge_cyl;
                    end
                    else
                    begin
                        phase_next = S_PASS;
                        consume    = 1'b1;
                    end
                end
            end

            // Current sweep, up to the request cylinder
            S_SWEEP:
            begin
                scan_step = 1'b1;
                consume   = dir_reg ? (sts.e_le_cyl && !sts.prev_gt_e)
                                    : (sts.e_ge_cyl && !sts.prev_lt_e);
            end

            // Step over the rest of the current sweep
            S_PASS:
            begin
                scan_step = 1'b1;
                if (dir_reg ? !sts.prev_gt_e : !sts.prev_lt_e)
                begin
                    consume = 1'b1;
                end
                else
                begin
                    phase_next = S_RETURN;
                    consume    = dir_reg ? sts.e_ge_cyl : sts.e_le_cyl;
                end
            end

            // Return sweep
            S_RETURN:
            begin
                scan_step = 1'b1;
                consume   = dir_reg ? sts.e_ge_cyl : sts.e_le_cyl;
            end

            // Move entries up from the tail down to the slot
            S_SHIFT:
            begin
                cmd.wr_sel = WR_UP;
                if (sts.idx_at_pos)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    cmd.idx_sel = IDX_DEC;
                end
            end

            S_WRITE:
            begin
                cmd.wr_sel    = WR_NEW;
                cmd.count_inc = 1'b1;
                cmd.finish    = 1'b1;
                state_next    = S_IDLE;
            end

            S_POP_HEAD:
            begin
                cmd.take_head = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.count_dec = 1'b1;
                    cmd.finish    = 1'b1;
                    cmd.pop_ok    = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.idx_sel = IDX_INC;
                    state_next  = S_POP_SHIFT;
                end
            end

            // Move entries down by one behind the popped head
            S_POP_SHIFT:
            begin
                cmd.wr_sel = WR_DOWN;
                if (sts.idx_last)
                begin
                    cmd.count_dec = 1'b1;
                    cmd.finish    = 1'b1;
                    cmd.pop_ok    = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.idx_sel = IDX_INC;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Common step of the slot search
        if (scan_step)
        begin
            if (consume)
            begin
                cmd.load_prev = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.pos_from_count = 1'b1;
                    state_next         = S_WRITE;
                end
                else
                begin
                    cmd.idx_sel = IDX_INC;
                    state_next  = phase_next;
                end
            end
            else
            begin
                cmd.pos_from_idx = 1'b1;
                cmd.idx_sel      = IDX_LAST;
                state_next       = S_SHIFT;
            end
        end
    end

    assign done_next = cmd.finish;

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dir_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dir_reg   <= dir_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while busy");

    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_INSERT && sts.count_full) |=> done_reg)
        else $error("full insert not answered next cycle");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_FIRST || state_reg == S_SKIP || state_reg == S_SWEEP
         || state_reg == S_PASS || state_reg == S_RETURN) |-> !sts.count_zero)
        else $error("slot search on an empty table");
`endif

endmodule

// ===== rtl/core/elevator_request_queue.sv =====
// Elevator-ordered queue of disk requests. A request is taken when start is
// high and busy is low; op 0 inserts (cylinder, tag), op 1 pops the head.
// Exactly one result follows each request, shown for one cycle with done
// high; the receiver cannot stall, so capture it on that cycle. An insert
// into a full queue or a pop of an empty queue answers on the next cycle
// with status full or empty. An insert into an empty queue goes straight
// to the final write. Otherwise the slot search reads one entry a cycle
// from the single-port-read table; when later entries must move up, the
// shift then moves one entry a cycle, and the final write and the result
// follow. A pop reads the head, then makes n-1 shift moves for n entries.
// The next request may be issued in the cycle done is high.
module elevator_request_queue #(
    parameter int DEPTH    = 16,
    parameter int CYL_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        op,
    input  logic [15:0] cylinder,
    input  logic [7:0]  tag,
    output logic [1:0]  status,
    output logic [3:0]  position,
    output logic [15:0] head_cylinder,
    output logic [7:0]  head_tag
);
    import erq_pkg::*;

    erq_cmd_t cmd;
    erq_sts_t sts;

    erq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    erq_dpath #(
        .DEPTH    (DEPTH),
        .CYL_BITS (CYL_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cylinder      (cylinder),
        .tag           (tag),
        .status        (status),
        .position      (position),
        .head_cylinder (head_cylinder),
        .head_tag      (head_tag)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import erq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYL_BITS    = 16;
    localparam int RAND_COUNT  = 1950;
    localparam int CYCLE_LIMIT = 400000;
    localparam int QUIET_FIRST = 800;
    localparam int QUIET_LAST  = 1200;
    localparam bit FIXED       = 1'b1;
    localparam bit PREDICT     = 1'b0;

    // One response as seen on the result ports
    typedef struct packed {
        status_t     status;
        logic [3:0]  position;
        logic [15:0] head_cyl;
        logic [7:0]  head_tag;
    } queue_resp_t;

    // One row of the directed request plan
    typedef struct packed {
        logic        op;
        logic [15:0] cyl;
        logic [7:0]  tag;
        bit          fixed;
        queue_resp_t resp;
    } plan_row_t;

    localparam queue_resp_t RESP_NONE = '{ST_OK, 4'd0, 16'd0, 8'd0};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        op = OP_INSERT;
    logic [15:0] cylinder = 16'd0;
    logic [7:0]  tag = 8'd0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [3:0]  position;
    logic [15:0] head_cylinder;
    logic [7:0]  head_tag;

    // Shadow copy of the queue contents
    logic [CYL_BITS-1:0] shadow_cyl [DEPTH];
    logic [7:0]          shadow_tag [DEPTH];
    int unsigned         shadow_count = 0;

    queue_resp_t expected_responses [$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          idle_enable = 1'b1;

    elevator_request_queue #(
        .DEPTH    (DEPTH),
        .CYL_BITS (CYL_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .done          (done),
        .op            (op),
        .cylinder      (cylinder),
        .tag           (tag),
        .status        (status),
        .position      (position),
        .head_cylinder (head_cylinder),
        .head_tag      (head_tag)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Elevator slot search over the shadow table
    function automatic int unsigned elevator_slot(logic [CYL_BITS-1:0] cyl);
        int unsigned n;
        int unsigned p;
        int unsigned q;
        n = shadow_count;
        if (n == 0)
            return 0;
        // skip leading run of equal cylinders
        p = 0;
        q = 1;
        while (q < n && shadow_cyl[p] == shadow_cyl[q])
        begin
            p = q;
            q++;
        end
        if (q >= n)
            return n;
        if (shadow_cyl[p] < shadow_cyl[q])
        begin
            // ascending first sweep
            if (shadow_cyl[p] <= cyl)
            begin
                while (q < n && shadow_cyl[q] <= cyl && shadow_cyl[p] <= shadow_cyl[q])
                begin
                    p = q;
                    q++;
                end
            end
            else
            begin
                do
                begin
                    p = q;
                    q++;
                end while (q < n && shadow_cyl[p] <= shadow_cyl[q]);
                while (q < n && shadow_cyl[q] >= cyl)
                begin
                    p = q;
                    q++;
                end
            end
        end
        else
        begin
            // descending first sweep
            if (shadow_cyl[p] >= cyl)
            begin
                while (q < n && shadow_cyl[q] >= cyl && shadow_cyl[p] >= shadow_cyl[q])
                begin
                    p = q;
                    q++;
                end
            end
            else
            begin
                do
                begin
                    p = q;
                    q++;
                end while (q < n && shadow_cyl[p] >= shadow_cyl[q]);
                while (q < n && shadow_cyl[q] <= cyl)
                begin
                    p = q;
                    q++;
                end
            end
        end
        return q;
    endfunction

    // Apply one request to the shadow queue and return its response
    function automatic queue_resp_t predict_queue_response(logic op_i, logic [15:0] cyl_i,
                                                           logic [7:0] tag_i);
        queue_resp_t         resp;
        logic [CYL_BITS-1:0] cyl;
        int unsigned         pos;
        resp = RESP_NONE;
        cyl  = cyl_i[CYL_BITS-1:0];
        if (op_i == OP_INSERT)
        begin
            if (shadow_count >= DEPTH)
            begin
                resp.status = ST_FULL;
                return resp;
            end
            pos = elevator_slot(cyl);
            if (pos > shadow_count)
                pos = shadow_count;
            for (int i = shadow_count; i > pos; i--)
            begin
                shadow_cyl[i] = shadow_cyl[i-1];
                shadow_tag[i] = shadow_tag[i-1];
            end
            shadow_cyl[pos] = cyl;
            shadow_tag[pos] = tag_i;
            shadow_count++;
            resp.position = pos[3:0];
            return resp;
        end
        if (shadow_count == 0)
        begin
            resp.status = ST_EMPTY;
            return resp;
        end
        resp.head_cyl = 16'(shadow_cyl[0]);
        resp.head_tag = shadow_tag[0];
        for (int i = 1; i < shadow_count; i++)
        begin
            shadow_cyl[i-1] = shadow_cyl[i];
            shadow_tag[i-1] = shadow_tag[i];
        end
        shadow_count--;
        return resp;
    endfunction

    // Present one request, wait for it to be taken, then maybe idle a while
    task automatic issue_request(input logic op_i, input logic [15:0] cyl_i,
                                 input logic [7:0] tag_i, input bit fixed_i,
                                 input queue_resp_t fixed_resp);
        queue_resp_t predicted;
        start    <= 1'b1;
        op       <= op_i;
        cylinder <= cyl_i;
        tag      <= tag_i;
        do
            @(posedge clk);
        while (busy);
        predicted = predict_queue_response(op_i, cyl_i, tag_i);
        expected_responses.push_back(fixed_i ? fixed_resp : predicted);
        if (idle_enable && $urandom_range(99) < 16)
        begin
            // idle with junk on the payload, start low, until the block is free
            start    <= 1'b0;
            op       <= 1'($urandom_range(1));
            cylinder <= 16'($urandom_range(65535));
            tag      <= 8'($urandom_range(255));
            do
                @(posedge clk);
            while (busy || $urandom_range(99) < 40);
        end
    endtask

    // Response checker
    always @(posedge clk)
    begin
        queue_resp_t want;
        if (rst_n && done)
        begin
            if (expected_responses.size() == 0)
            begin
                $display("%0t: response with no request pending: status %0d position %0d",
                         $time, status, position);
                error_count++;
            end
            else
            begin
                want = expected_responses.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                    error_count++;
                end
                if (position !== want.position)
                begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, position);
                    error_count++;
                end
                if (head_cylinder !== want.head_cyl)
                begin
                    $display("%0t: head_cylinder expected %0d actual %0d",
                             $time, want.head_cyl, head_cylinder);
                    error_count++;
                end
                if (head_tag !== want.head_tag)
                begin
                    $display("%0t: head_tag expected %0d actual %0d",
                             $time, want.head_tag, head_tag);
                    error_count++;
                end
            end
        end
    end

    // Run timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        plan_row_t   plan [23];
        int          insert_pct;
        logic        r_op;
        logic [15:0] r_cyl;
        logic [7:0]  r_tag;

        // empty pop, lone insert, then fill past full with sweeps and extremes
        plan = '{
            '{OP_POP,    16'd0,     8'h00, FIXED,   '{ST_EMPTY, 4'd0, 16'd0,    8'h00}},
            '{OP_INSERT, 16'd4660,  8'hA5, FIXED,   '{ST_OK,    4'd0, 16'd0,    8'h00}},
            '{OP_POP,    16'd0,     8'h00, FIXED,   '{ST_OK,    4'd0, 16'd4660, 8'hA5}},
            '{OP_INSERT, 16'd500,   8'h00, FIXED,   '{ST_OK,    4'd0, 16'd0,    8'h00}},
            '{OP_INSERT, 16'd500,   8'hFF, FIXED,   '{ST_OK,    4'd1, 16'd0,    8'h00}},
            '{OP_INSERT, 16'd500,   8'h01, FIXED,   '{ST_OK,    4'd2, 16'd0,    8'h00}},
            '{OP_INSERT, 16'd800,   8'h02, PREDICT, RESP_NONE},
            '{OP_INSERT, 16'hFFFF,  8'h03, PREDICT, RESP_NONE},
            '{OP_INSERT, 16'd0,     8'h04, PREDICT, RESP_NONE},
            '{OP_INSERT, 16'd600,   8'h05, PREDICT, RESP_NONE},
            '{OP_INSERT, 16'd100,   8'h06, PREDICT, RESP_NONE},
            '{OP_INSERT, 16'hFFFF,  8'h07, PREDICT, RESP_NONE},
            '{OP_INSERT, 16'd0,     8'hFF, PREDICT, RESP_NONE},
            '{OP_INSERT, 16'd300,   8'h08, PREDICT, RESP_NONE},
            '{OP_INSERT, 16'd700,   8'h09, PREDICT, RESP_NONE},
            '{OP_INSERT, 16'd200,   8'h0A, PREDICT, RESP_NONE},
            '{OP_INSERT, 16'd50000, 8'h0B, PREDICT, RESP_NONE},
            '{OP_INSERT, 16'd1,     8'h0C, PREDICT, RESP_NONE},
            '{OP_INSERT, 16'd65534, 8'h0D, PREDICT, RESP_NONE},
            '{OP_INSERT, 16'd1234,  8'h0E, FIXED,   '{ST_FULL,  4'd0, 16'd0,    8'h00}},
            '{OP_POP,    16'hFFFF,  8'hFF, FIXED,   '{ST_OK,    4'd0, 16'd500,  8'h00}},
            '{OP_POP,    16'd0,     8'h00, PREDICT, RESP_NONE},
            '{OP_POP,    16'd0,     8'h00, PREDICT, RESP_NONE}
        };

        // hold reset, then release it
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests
        foreach (plan[i])
            issue_request(plan[i].op, plan[i].cyl, plan[i].tag, plan[i].fixed, plan[i].resp);

        // random requests; insert bias drifts so the queue hits full and empty
        insert_pct = 50;
        for (int n = 0; n < RAND_COUNT; n++)
        begin
            if (n % 64 == 0)
            begin
                case ($urandom_range(2))
                    0: insert_pct = 25;
                    1: insert_pct = 50;
                    default: insert_pct = 80;
                endcase
            end
            idle_enable = !(n >= QUIET_FIRST && n < QUIET_LAST);
            r_op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_POP;
            // mix wide cylinders with clusters that make equal runs
            case ($urandom_range(3))
                0: r_cyl = 16'($urandom_range(65535));
                1: r_cyl = 16'(1000 + $urandom_range(7));
                2: r_cyl = $urandom_range(1) ? 16'(65535 - $urandom_range(3))
                                             : 16'($urandom_range(3));
                default: r_cyl = 16'($urandom_range(31));
            endcase
            r_tag = 8'($urandom_range(255));
            issue_request(r_op, r_cyl, r_tag, PREDICT, RESP_NONE);
        end
        start <= 1'b0;

        // drain, then allow the longest request time
        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
        if (error_count == 0 && expected_responses.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
